// ===== design/ffa_pkg.sv =====
// Shared types and constants for the first-fit free-list allocator.
// No dependencies; used by ffa_ctrl, ffa_dpath and the top level.
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int BYTES_W   = 18;  // request byte count
    localparam int UNIT_W    = 14;  // payload unit index on the ports
    localparam int NUM_W     = 19;  // rounded byte count fed to the divider
    localparam int NEED_W    = 20;  // unit count of a request, header included

    typedef struct packed {
        logic               opcode;
        logic [BYTES_W-1:0] request_bytes;
        logic [UNIT_W-1:0]  block_unit;
    } req_t;

    typedef struct packed {
        logic [UNIT_W-1:0] payload_unit;
        logic              status;
    } rsp_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_OOM = 1'b1;

    typedef logic [4:0] cmd_t;

    localparam cmd_t CMD_NOP      = 5'd0;
    localparam cmd_t CMD_LOAD     = 5'd1;
    localparam cmd_t CMD_START    = 5'd2;
    localparam cmd_t CMD_DIV      = 5'd3;
    localparam cmd_t CMD_AR0      = 5'd4;
    localparam cmd_t CMD_AR1      = 5'd5;
    localparam cmd_t CMD_A_UNLINK = 5'd6;
    localparam cmd_t CMD_A_SPLIT1 = 5'd7;
    localparam cmd_t CMD_A_SPLIT2 = 5'd8;
    localparam cmd_t CMD_A_FAIL   = 5'd9;
    localparam cmd_t CMD_A_GROW   = 5'd10;
    localparam cmd_t CMD_A_ADV    = 5'd11;
    localparam cmd_t CMD_F_R0     = 5'd12;
    localparam cmd_t CMD_F_FOUND  = 5'd13;
    localparam cmd_t CMD_F_ADV    = 5'd14;
    localparam cmd_t CMD_F_DONE   = 5'd15;
    localparam cmd_t CMD_F_RN     = 5'd16;
    localparam cmd_t CMD_F_WB     = 5'd17;
    localparam cmd_t CMD_F_WC     = 5'd18;
    localparam cmd_t CMD_G_RET    = 5'd19;
    localparam cmd_t CMD_FIN      = 5'd20;

    typedef struct packed {
        logic is_free;
        logic bad_free;
        logic fit;
        logic exact;
        logic at_rover;
        logic grow_bad;
        logic alloc_lim;
        logic found;
        logic free_lim;
        logic in_grow;
    } stat_t;

endpackage

// ===== design/ffa_ctrl.sv =====
// Sequencer for the allocator: walks allocate and free operations step by step.
// Depends on ffa_pkg; drives ffa_dpath through command codes.
`timescale 1ns / 1ps

module ffa_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  ffa_pkg::stat_t stat,
    output ffa_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_AR0    = 4'd3;
    localparam logic [3:0] S_AR1    = 4'd4;
    localparam logic [3:0] S_ACHK   = 4'd5;
    localparam logic [3:0] S_SPLIT2 = 4'd6;
    localparam logic [3:0] S_FR0    = 4'd7;
    localparam logic [3:0] S_FLOOP  = 4'd8;
    localparam logic [3:0] S_FRN    = 4'd9;
    localparam logic [3:0] S_FRNX   = 4'd10;
    localparam logic [3:0] S_FWC    = 4'd11;
    localparam logic [3:0] S_GRET   = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = ffa_pkg::CMD_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = ffa_pkg::CMD_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd = ffa_pkg::CMD_START;
                if (!stat.is_free)
                    state_next = S_DIV;
                else if (stat.bad_free)
                    state_next = S_FIN;
                else
                    state_next = S_FR0;
            end
            S_DIV:
            begin
                cmd        = ffa_pkg::CMD_DIV;
                state_next = S_AR0;
            end
            S_AR0:
            begin
                cmd        = ffa_pkg::CMD_AR0;
                state_next = S_AR1;
            end
            S_AR1:
            begin
                cmd        = ffa_pkg::CMD_AR1;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                priority if (stat.fit && stat.exact)
                begin
                    cmd        = ffa_pkg::CMD_A_UNLINK;
                    state_next = S_FIN;
                end
                else if (stat.fit)
                begin
                    cmd        = ffa_pkg::CMD_A_SPLIT1;
                    state_next = S_SPLIT2;
                end
                else if (stat.at_rover && stat.grow_bad)
                begin
                    cmd        = ffa_pkg::CMD_A_FAIL;
                    state_next = S_FIN;
                end
                else if (stat.at_rover)
                begin
                    cmd        = ffa_pkg::CMD_A_GROW;
                    state_next = S_FR0;
                end
                else if (stat.alloc_lim)
                begin
                    cmd        = ffa_pkg::CMD_A_FAIL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd = ffa_pkg::CMD_A_ADV;
                end
            end
            S_SPLIT2:
            begin
                cmd        = ffa_pkg::CMD_A_SPLIT2;
                state_next = S_FIN;
            end
            S_FR0:
            begin
                cmd        = ffa_pkg::CMD_F_R0;
                state_next = S_FLOOP;
            end
            S_FLOOP:
            begin
                priority if (stat.found)
                begin
                    cmd        = ffa_pkg::CMD_F_FOUND;
                    state_next = S_FRN;
                end
                else if (stat.free_lim)
                begin
                    cmd        = stat.in_grow ? ffa_pkg::CMD_A_FAIL : ffa_pkg::CMD_F_DONE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd = ffa_pkg::CMD_F_ADV;
                end
            end
            S_FRN:
            begin
                cmd        = ffa_pkg::CMD_F_RN;
                state_next = S_FRNX;
            end
            S_FRNX:
            begin
                cmd        = ffa_pkg::CMD_F_WB;
                state_next = S_FWC;
            end
            S_FWC:
            begin
                cmd        = ffa_pkg::CMD_F_WC;
                state_next = stat.in_grow ? S_GRET : S_FIN;
            end
            S_GRET:
            begin
                if (stat.alloc_lim)
                begin
                    cmd        = ffa_pkg::CMD_A_FAIL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = ffa_pkg::CMD_G_RET;
                    state_next = S_AR0;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!(rsp_valid_reg && !rsp_ready))
                begin
                    cmd        = ffa_pkg::CMD_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = (cmd == ffa_pkg::CMD_FIN) || (rsp_valid_reg && !rsp_ready);
    assign rsp_valid      = rsp_valid_reg;
    assign req_ready      = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== design/ffa_dpath.sv =====
// Datapath for the allocator: header memory, walk registers, divider, result.
// Depends on ffa_pkg; commanded by ffa_ctrl.
`timescale 1ns / 1ps

module ffa_dpath
#(
    parameter int HEAP_UNITS     = 16384,
    parameter int MIN_GROW_UNITS = 1024,
    parameter int UNIT_BYTES     = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  ffa_pkg::cmd_t  cmd,
    input  ffa_pkg::req_t  req,
    output ffa_pkg::stat_t stat,
    output ffa_pkg::rsp_t  rsp
);

    localparam int IW = $clog2(HEAP_UNITS);
    localparam int SW = IW + 1;
    localparam int HW = IW + SW;
    localparam int SA = IW + 2;
    localparam int CW = (SW > ffa_pkg::UNIT_W) ? SW : ffa_pkg::UNIT_W;
    localparam int GW = ffa_pkg::NEED_W + 1;
    // reciprocal of UNIT_BYTES, exact for every numerator below 2^NUM_W
    localparam int DSH = ffa_pkg::NUM_W + $clog2(UNIT_BYTES);
    localparam int MW  = ffa_pkg::NUM_W + 1;
    localparam int PW  = ffa_pkg::NUM_W + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) << DSH) + longint'(UNIT_BYTES) - 1) / longint'(UNIT_BYTES));

    // header memory {next, size}
    logic [HW-1:0] mem [HEAP_UNITS];
    logic [HW-1:0] mem_q;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [HW-1:0] wr_data;

    logic [IW-1:0] rover_reg;
    logic [SW-1:0] brk_reg;
    logic          started_reg;
    logic          in_grow_reg;
    logic          op_reg;
    logic [ffa_pkg::UNIT_W-1:0]    unit_reg;
    logic [ffa_pkg::NUM_W-1:0]     num_reg;
    logic [ffa_pkg::NUM_W-1:0]     quo_reg;
    logic [SA-1:0] stepa_reg;
    logic [SA-1:0] stepf_reg;
    logic [IW-1:0] prv_reg;
    logic [SW-1:0] prvs_reg;
    logic [IW-1:0] cur_reg;
    logic [SW-1:0] curs_reg;
    logic [IW-1:0] nx_reg;
    logic [IW-1:0] blk_reg;
    logic [IW-1:0] blkn_reg;
    logic [SW-1:0] blks_reg;
    logic [ffa_pkg::UNIT_W-1:0] res_pay_reg;
    logic                       res_st_reg;
    ffa_pkg::rsp_t              out_reg;

    logic [IW-1:0] q_next;
    logic [SW-1:0] q_size;
    logic [ffa_pkg::NEED_W-1:0] need;
    logic [ffa_pkg::NEED_W-1:0] grow;
    logic [ffa_pkg::NEED_W-1:0] q_size_x;
    logic [PW-1:0] prod;
    logic [SW-1:0] new_size;
    logic [SA-1:0] split_sum;
    logic [IW-1:0] split_addr;
    logic [CW-1:0] unit_m1;
    logic          merge_up;
    logic          merge_lo;
    logic [IW-1:0] wb_next;
    logic [SW-1:0] wb_size;

    assign q_next   = mem_q[HW-1:SW];
    assign q_size   = mem_q[SW-1:0];
    assign need     = ffa_pkg::NEED_W'(quo_reg) + ffa_pkg::NEED_W'(1);
    assign grow     = (need < ffa_pkg::NEED_W'(MIN_GROW_UNITS)) ?
                      ffa_pkg::NEED_W'(MIN_GROW_UNITS) : need;
    assign q_size_x = ffa_pkg::NEED_W'(q_size);

    // bytes to units by reciprocal multiply
    assign prod     = PW'(num_reg) * PW'(RECIP);

    assign new_size  = q_size - SW'(need);
    assign split_sum = SA'(cur_reg) + SA'(new_size);
    assign split_addr = (split_sum >= SA'(HEAP_UNITS)) ?
                        IW'(split_sum - SA'(HEAP_UNITS)) : IW'(split_sum);
    assign unit_m1   = CW'(unit_reg) - CW'(1);

    assign merge_up = (SA'(blk_reg) + SA'(blks_reg)) == SA'(nx_reg);
    assign merge_lo = (SA'(cur_reg) + SA'(curs_reg)) == SA'(blk_reg);
    assign wb_next  = merge_up ? q_next : nx_reg;
    assign wb_size  = merge_up ? SW'(blks_reg + q_size) : blks_reg;

    always_comb
    begin
        stat.is_free   = (op_reg == ffa_pkg::OP_FREE);
        stat.bad_free  = (unit_reg == '0) || (CW'(unit_reg) >= CW'(brk_reg));
        stat.fit       = q_size_x >= need;
        stat.exact     = q_size_x == need;
        stat.at_rover  = (cur_reg == rover_reg);
        stat.grow_bad  = (grow > ffa_pkg::NEED_W'(HEAP_UNITS)) ||
                         ((GW'(brk_reg) + GW'(grow)) > GW'(HEAP_UNITS));
        stat.alloc_lim = (stepa_reg == SA'(2 * HEAP_UNITS + 4));
        stat.found     = ((blk_reg > cur_reg) && (blk_reg < q_next)) ||
                         ((cur_reg >= q_next) &&
                          ((blk_reg > cur_reg) || (blk_reg < q_next)));
        stat.free_lim  = (stepf_reg == SA'(HEAP_UNITS + 2));
        stat.in_grow   = in_grow_reg;
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = rover_reg;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = {q_next, q_size};
        unique case (cmd)
            ffa_pkg::CMD_START:
            begin
                wr_en   = !started_reg;
                wr_addr = '0;
                wr_data = '0;
            end
            ffa_pkg::CMD_AR0, ffa_pkg::CMD_F_R0:
            begin
                rd_en = 1'b1;
            end
            ffa_pkg::CMD_AR1, ffa_pkg::CMD_A_ADV, ffa_pkg::CMD_F_ADV:
            begin
                rd_en   = 1'b1;
                rd_addr = q_next;
            end
            ffa_pkg::CMD_F_FOUND:
            begin
                rd_en   = 1'b1;
                rd_addr = blk_reg;
            end
            ffa_pkg::CMD_F_RN:
            begin
                rd_en   = 1'b1;
                rd_addr = nx_reg;
            end
            ffa_pkg::CMD_A_UNLINK:
            begin
                wr_en   = 1'b1;
                wr_addr = prv_reg;
                wr_data = {q_next, prvs_reg};
            end
            ffa_pkg::CMD_A_SPLIT1:
            begin
                wr_en   = 1'b1;
                wr_data = {q_next, new_size};
            end
            ffa_pkg::CMD_A_SPLIT2:
            begin
                wr_en   = 1'b1;
                wr_data = {IW'(0), SW'(need)};
            end
            ffa_pkg::CMD_A_GROW:
            begin
                wr_en   = 1'b1;
                wr_addr = brk_reg[IW-1:0];
                wr_data = {IW'(0), SW'(grow)};
            end
            ffa_pkg::CMD_F_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = blk_reg;
                wr_data = {wb_next, wb_size};
            end
            ffa_pkg::CMD_F_WC:
            begin
                wr_en   = 1'b1;
                wr_data = merge_lo ? {blkn_reg, SW'(curs_reg + blks_reg)}
                                   : {blk_reg, curs_reg};
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rover_reg   <= '0;
            brk_reg     <= SW'(1);
            started_reg <= 1'b0;
            in_grow_reg <= 1'b0;
            op_reg      <= ffa_pkg::OP_ALLOC;
            stepa_reg   <= '0;
            stepf_reg   <= '0;
        end
        else
        begin
            unique case (cmd)
                ffa_pkg::CMD_LOAD:
                begin
                    op_reg      <= req.opcode;
                    in_grow_reg <= 1'b0;
                    stepa_reg   <= '0;
                end
                ffa_pkg::CMD_START:
                begin
                    if (!started_reg)
                    begin
                        rover_reg   <= '0;
                        started_reg <= 1'b1;
                    end
                end
                ffa_pkg::CMD_A_UNLINK: rover_reg <= prv_reg;
                ffa_pkg::CMD_A_SPLIT1: rover_reg <= prv_reg;
                ffa_pkg::CMD_A_ADV:    stepa_reg <= stepa_reg + 1'b1;
                ffa_pkg::CMD_G_RET:    stepa_reg <= stepa_reg + 1'b1;
                ffa_pkg::CMD_A_GROW:
                begin
                    brk_reg     <= brk_reg + SW'(grow);
                    in_grow_reg <= 1'b1;
                end
                ffa_pkg::CMD_F_R0:     stepf_reg <= '0;
                ffa_pkg::CMD_F_ADV:    stepf_reg <= stepf_reg + 1'b1;
                ffa_pkg::CMD_F_WC:     rover_reg <= cur_reg;
                default:               op_reg    <= op_reg;
            endcase
        end
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            ffa_pkg::CMD_LOAD:
            begin
                unit_reg <= req.block_unit;
                num_reg  <= ffa_pkg::NUM_W'(req.request_bytes) +
                            ffa_pkg::NUM_W'(UNIT_BYTES - 1);
                quo_reg  <= '0;
            end
            ffa_pkg::CMD_START:
            begin
                blk_reg     <= unit_m1[IW-1:0];
                res_pay_reg <= '0;
                res_st_reg  <= ffa_pkg::ST_OK;
            end
            ffa_pkg::CMD_DIV:
            begin
                quo_reg <= ffa_pkg::NUM_W'(prod >> DSH);
            end
            ffa_pkg::CMD_AR0:
            begin
                prv_reg <= rover_reg;
            end
            ffa_pkg::CMD_AR1:
            begin
                prvs_reg <= q_size;
                cur_reg  <= q_next;
            end
            ffa_pkg::CMD_A_ADV:
            begin
                prv_reg  <= cur_reg;
                prvs_reg <= q_size;
                cur_reg  <= q_next;
            end
            ffa_pkg::CMD_A_UNLINK:
            begin
                res_pay_reg <= ffa_pkg::UNIT_W'(SW'(cur_reg) + SW'(1));
                res_st_reg  <= ffa_pkg::ST_OK;
            end
            ffa_pkg::CMD_A_SPLIT1:
            begin
                cur_reg <= split_addr;
            end
            ffa_pkg::CMD_A_SPLIT2:
            begin
                res_pay_reg <= ffa_pkg::UNIT_W'(SW'(cur_reg) + SW'(1));
                res_st_reg  <= ffa_pkg::ST_OK;
            end
            ffa_pkg::CMD_A_FAIL:
            begin
                res_pay_reg <= '0;
                res_st_reg  <= ffa_pkg::ST_OOM;
            end
            ffa_pkg::CMD_A_GROW:
            begin
                blk_reg <= brk_reg[IW-1:0];
            end
            ffa_pkg::CMD_F_R0:
            begin
                cur_reg <= rover_reg;
            end
            ffa_pkg::CMD_F_ADV:
            begin
                cur_reg <= q_next;
            end
            ffa_pkg::CMD_F_FOUND:
            begin
                curs_reg <= q_size;
                nx_reg   <= q_next;
            end
            ffa_pkg::CMD_F_DONE:
            begin
                res_pay_reg <= '0;
                res_st_reg  <= ffa_pkg::ST_OK;
            end
            ffa_pkg::CMD_F_RN:
            begin
                blkn_reg <= q_next;
                blks_reg <= q_size;
            end
            ffa_pkg::CMD_F_WB:
            begin
                blkn_reg <= wb_next;
                blks_reg <= wb_size;
            end
            ffa_pkg::CMD_FIN:
            begin
                out_reg.payload_unit <= res_pay_reg;
                out_reg.status       <= res_st_reg;
            end
            default:
            begin
                res_st_reg <= res_st_reg;
            end
        endcase
    end

    assign rsp = out_reg;

endmodule

// ===== design/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list allocator.
// Depends on ffa_pkg, ffa_ctrl and ffa_dpath.
`timescale 1ns / 1ps

// Usage:
//   req channel (req_valid/req_ready/req): one beat is one operation, either
//   allocate request_bytes or free the block whose payload starts at
//   block_unit. rsp channel (rsp_valid/rsp_ready/rsp): one beat per request,
//   in order, carrying the payload unit handed out (0 for a free or on
//   failure) and an out-of-memory status bit.
//   Requests are handled one at a time. All headers live in one memory with
//   a single registered read port, and every free-list step is one read, so
//   the cost is set by the list walk, which passes one free block per cycle:
//     allocate: one walk past the free blocks, with an extra write step on a
//               split, plus the free walk and the allocate walk again when the
//               heap break is grown;
//     free:     one walk past the free blocks; an ignored free skips the walk.
//   The next request is taken as soon as the result sits in the output
//   register; a stalled receiver only holds the block when a second result
//   is ready before the first was taken.
//   Reset empties the free list logically (rover at the sentinel, break at
//   unit 1); the header memory is not cleared and needs no sweep.

module first_fit_free_list_allocator
#(
    parameter int HEAP_UNITS     = 16384,
    parameter int MIN_GROW_UNITS = 1024,
    parameter int UNIT_BYTES     = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ffa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ffa_pkg::rsp_t rsp
);

    ffa_pkg::cmd_t  cmd;
    ffa_pkg::stat_t stat;

    // sequencer: decides one datapath step per cycle
    ffa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // header memory, walk registers and the byte-to-unit divider
    ffa_dpath
    #(
        .HEAP_UNITS     (HEAP_UNITS),
        .MIN_GROW_UNITS (MIN_GROW_UNITS),
        .UNIT_BYTES     (UNIT_BYTES)
    )
    u_dpath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .stat  (stat),
        .rsp   (rsp)
    );

    // a result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == ffa_pkg::CMD_FIN) |-> !(rsp_valid && !rsp_ready))
        else $error("result overwritten while stalled");

    // an accepted beat makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second beat taken while busy");

    // a failure never hands out a unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ffa_pkg::ST_OOM) |-> (rsp.payload_unit == '0))
        else $error("out-of-memory result with nonzero unit");

    // the divider only runs on allocate requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == ffa_pkg::CMD_DIV) |-> !stat.is_free)
        else $error("divider stepped on a free");

endmodule
